// ----- rtl/core/mctc_pkg.sv -----
// Shared constants and helpers for the minute countdown timer controller.
// Holds key codes, the seven-segment table and the decimal digit split.
// No dependencies.
`timescale 1ns / 1ps

package mctc_pkg;

  typedef logic [1:0] key_code_t;

  localparam key_code_t KEY_NONE   = 2'd0;
  localparam key_code_t KEY_SELECT = 2'd1;
  localparam key_code_t KEY_SET    = 2'd2;
  localparam key_code_t KEY_RUN    = 2'd3;

  localparam logic [6:0] TICKS_PER_SECOND = 7'd125;
  localparam logic [6:0] BLINK_ON_TICK    = 7'd63;
  localparam logic [6:0] BLINK_OFF_TICK   = 7'd1;
  localparam logic [6:0] MINUTES_MAX      = 7'd99;
  localparam logic [5:0] SECONDS_MAX      = 6'd59;
  localparam logic [7:0] DEBOUNCE_RESET   = 8'd5;
  localparam logic [6:0] PRESET_RESET     = 7'd8;
  localparam logic [7:0] SEG_BLANK        = 8'hff;

  // Active-low seven-segment code; codes above nine show blank.
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0:    seg = ~8'h3f;
      4'd1:    seg = ~8'h06;
      4'd2:    seg = ~8'h5b;
      4'd3:    seg = ~8'h4f;
      4'd4:    seg = ~8'h66;
      4'd5:    seg = ~8'h6d;
      4'd6:    seg = ~8'h7d;
      4'd7:    seg = ~8'h07;
      4'd8:    seg = ~8'h7f;
      4'd9:    seg = ~8'h6f;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

  // Tens digit by reciprocal multiply; exact for every 7-bit value.
  function automatic logic [3:0] tens_of(input logic [6:0] value);
    logic [14:0] prod;
    prod = 15'(value) * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] value);
    logic [6:0] rem;
    rem = value - 7'(tens_of(value)) * 7'd10;
    return rem[3:0];
  endfunction

endpackage

// ----- rtl/core/minute_countdown_timer_controller.sv -----
// Minute countdown timer controller top level.
// Depends on mctc_pkg for key codes, segment table and digit helpers.
// Usage:
//   One slave word per 8 ms tick carries the raw active-low key sample in
//   s_tdata[2:0] (bit0 run/stop, bit1 set, bit2 select, rest zero).
//   Each accepted word yields exactly one master word:
//     m_tdata[7:0]   segments (active-low a..g, dot in bit 7)
//     m_tdata[8]     digit_select (1 = tens)
//     m_tdata[9]     relay_on
//     m_tdata[16:10] minutes_left
//     m_tdata[22:17] seconds_left, m_tdata[23] zero.
//   The whole tick update is combinational from the state registers into
//   the output register, so a word can be taken every cycle while the
//   receiver does not stall. The single output register sets that rate.
//   When the receiver stalls, the output word holds and s_tready drops
//   until it is taken; s_tready stays high while the output word is taken
//   in the same cycle.
//   Reset (rst, synchronous) restores 8:00 stopped with tens flashing,
//   debounce_ticks 5, and empties the output register.
//   The user writes debounce_ticks through cfg_wr_en / cfg_wr_data only while idle; the block does not enforce it.
`timescale 1ns / 1ps

module minute_countdown_timer_controller
  import mctc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [2:0] key_sample, [7:3] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // segments, digit_select, relay_on,
                                 // minutes_left, seconds_left, zero pad
);

  logic [7:0] debounce_ticks;
  logic [6:0] tick_count, tick_count_next;
  logic [5:0] seconds, seconds_next;
  logic [6:0] minutes, minutes_next;
  logic [6:0] preset_minutes, preset_minutes_next;
  logic       running, running_next;
  logic       blink_phase, blink_phase_next;
  logic       scan_tens, scan_tens_next;
  logic       flash_ones, flash_ones_next;
  logic       flash_tens, flash_tens_next;
  key_code_t  last_key, last_key_next;
  logic [7:0] key_count, key_count_next;

  logic [7:0] seg;
  logic       dsel;
  logic       key_pending;
  key_code_t  code;
  logic [3:0] tens_digit, ones_digit;
  logic       accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    tick_count_next     = tick_count + 7'd1;
    seconds_next        = seconds;
    minutes_next        = minutes;
    preset_minutes_next = preset_minutes;
    running_next        = running;
    blink_phase_next    = blink_phase;
    flash_ones_next     = flash_ones;
    flash_tens_next     = flash_tens;
    last_key_next       = last_key;
    key_count_next      = key_count;
    key_pending         = 1'b0;

    // Tick counter, blink phase and once-a-second countdown.
    if (tick_count_next == BLINK_OFF_TICK) begin
      blink_phase_next = 1'b0;
    end else if (tick_count_next == BLINK_ON_TICK) begin
      blink_phase_next = 1'b1;
    end else if (tick_count_next == TICKS_PER_SECOND) begin
      tick_count_next = '0;
      if (running) begin
        if (seconds == '0) begin
          seconds_next = SECONDS_MAX;
          if (minutes != '0) minutes_next = minutes - 7'd1;
        end else begin
          seconds_next = seconds - 6'd1;
        end
      end
    end

    // Display shows the minutes before this tick's key action.
    tens_digit = tens_of(minutes_next);
    ones_digit = ones_of(minutes_next);
    scan_tens_next = !scan_tens;
    if (scan_tens) begin
      dsel = 1'b1;
      seg  = seg_code(tens_digit);
      if (flash_tens && blink_phase_next) seg = SEG_BLANK;
    end else begin
      dsel = 1'b0;
      seg  = seg_code(ones_digit);
      if (flash_ones && blink_phase_next) seg = SEG_BLANK;
      if (running && blink_phase_next) seg[7] = 1'b0;
    end

    // Only a pattern with exactly one key low is a key.
    unique case (s_tdata[2:0])
      3'b011:  code = KEY_SELECT;
      3'b101:  code = KEY_SET;
      3'b110:  code = KEY_RUN;
      default: code = KEY_NONE;
    endcase

    if (code != KEY_NONE) begin
      if (code == last_key) begin
        key_count_next = key_count + 8'd1;
        if (key_count_next >= debounce_ticks) begin
          key_pending    = 1'b1;
          key_count_next = '0;
        end
      end else begin
        last_key_next  = code;
        key_count_next = '0;
      end
    end else begin
      key_count_next = '0;
      last_key_next  = KEY_NONE;
    end

    if (key_pending) begin
      if (running) begin
        unique case (last_key_next)
          KEY_SELECT: begin
            if (minutes_next < MINUTES_MAX) minutes_next = minutes_next + 7'd1;
          end
          KEY_SET: begin
            if (minutes_next != '0) minutes_next = minutes_next - 7'd1;
            else seconds_next = '0;
          end
          KEY_RUN: begin
            running_next     = 1'b0;
            blink_phase_next = 1'b0;
            scan_tens_next   = 1'b0;
            flash_ones_next  = 1'b0;
            flash_tens_next  = 1'b1;
          end
          default: ;
        endcase
      end else begin
        unique case (last_key_next)
          KEY_SELECT: begin
            flash_tens_next = flash_ones;
            flash_ones_next = !flash_ones;
          end
          KEY_SET: begin
            if (flash_tens) begin
              if (tens_digit == 4'd9) minutes_next = minutes_next - 7'd90;
              else minutes_next = minutes_next + 7'd10;
            end else begin
              if (ones_digit == 4'd9) minutes_next = minutes_next - 7'd9;
              else minutes_next = minutes_next + 7'd1;
            end
          end
          KEY_RUN: begin
            if (minutes_next != '0) begin
              running_next        = 1'b1;
              flash_tens_next     = 1'b0;
              flash_ones_next     = 1'b0;
              tick_count_next     = '0;
              preset_minutes_next = minutes_next;
            end
          end
          default: ;
        endcase
      end
      last_key_next = KEY_NONE;
    end

    // At 0:00 the timer stops and reloads the preset.
    if (minutes_next == '0 && seconds_next == '0) begin
      running_next     = 1'b0;
      blink_phase_next = 1'b0;
      scan_tens_next   = 1'b0;
      flash_ones_next  = 1'b0;
      flash_tens_next  = 1'b1;
      tick_count_next  = '0;
      minutes_next     = preset_minutes_next;
      seconds_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      tick_count     <= '0;
      seconds        <= '0;
      minutes        <= PRESET_RESET;
      preset_minutes <= PRESET_RESET;
      running        <= 1'b0;
      blink_phase    <= 1'b0;
      scan_tens      <= 1'b0;
      flash_ones     <= 1'b0;
      flash_tens     <= 1'b1;
      last_key       <= KEY_NONE;
      key_count      <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_wr_en) debounce_ticks <= cfg_wr_data;
      if (accept) begin
        tick_count     <= tick_count_next;
        seconds        <= seconds_next;
        minutes        <= minutes_next;
        preset_minutes <= preset_minutes_next;
        running        <= running_next;
        blink_phase    <= blink_phase_next;
        scan_tens      <= scan_tens_next;
        flash_ones     <= flash_ones_next;
        flash_tens     <= flash_tens_next;
        last_key       <= last_key_next;
        key_count      <= key_count_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0, seconds_next, minutes_next, running_next, dsel, seg};
    end
  end

endmodule

// ----- test/minute_countdown_timer_controller_tb.sv -----
// Self-checking testbench for the minute countdown timer controller.
// A directed table and random key-press traffic are checked word by word against
// an in-bench model of the tick logic, or a typed row's own word; depends on mctc_pkg.
`timescale 1ns / 1ps

module minute_countdown_timer_controller_tb;
  import mctc_pkg::*;

  // Raw active-low key patterns; only one low bit counts as a key.
  localparam logic [2:0] PAT_NONE   = 3'b111;
  localparam logic [2:0] PAT_ALL    = 3'b000;
  localparam logic [2:0] PAT_SELECT = 3'b011;
  localparam logic [2:0] PAT_SET    = 3'b101;
  localparam logic [2:0] PAT_RUN    = 3'b110;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SINK_HOLD       = 250;
  localparam int HOLD_AFTER      = 400;
  localparam int RANDOM_DEBOUNCE = -1;
  localparam int NUM_PHASES      = 7;
  localparam int NUM_ROWS        = 23;

  localparam int PHASE_DEBOUNCE [NUM_PHASES] = '{5, 0, 1, 255, 2, RANDOM_DEBOUNCE, 3};
  localparam int PHASE_ITEMS [NUM_PHASES]    = '{150, 150, 150, 300, 100, 100, 100};

  localparam logic [7:0] DIGIT_GLYPHS [10] = '{8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99,
                                               8'h92, 8'h82, 8'hf8, 8'h80, 8'h90};

  typedef struct packed {
    logic       pad;
    logic [5:0] seconds;
    logic [6:0] minutes;
    logic       relay_on;
    logic       digit_sel;
    logic [7:0] segments;
  } tick_word_t;

  typedef struct packed {
    logic [2:0]  keys;
    logic        typed;
    logic [23:0] word;
  } stim_row_t;

  // Right after reset the display shows 8 on the ones digit, then 0 on the tens.
  stim_row_t directed_rows [NUM_ROWS] = '{
    {PAT_NONE,   1'b1, 24'h002080},
    {PAT_ALL,    1'b1, 24'h0021c0},
    {3'b001,     1'b1, 24'h002080},
    {3'b010,     1'b1, 24'h0021c0},
    {3'b100,     1'b1, 24'h002080},
    {PAT_SELECT, 1'b0, 24'h0}, {PAT_SELECT, 1'b0, 24'h0}, {PAT_SELECT, 1'b0, 24'h0},
    {PAT_SELECT, 1'b0, 24'h0}, {PAT_SELECT, 1'b0, 24'h0}, {PAT_SELECT, 1'b0, 24'h0},
    {PAT_SET,    1'b0, 24'h0}, {PAT_SET,    1'b0, 24'h0}, {PAT_SET,    1'b0, 24'h0},
    {PAT_SET,    1'b0, 24'h0}, {PAT_SET,    1'b0, 24'h0}, {PAT_SET,    1'b0, 24'h0},
    {PAT_RUN,    1'b0, 24'h0}, {PAT_RUN,    1'b0, 24'h0}, {PAT_RUN,    1'b0, 24'h0},
    {PAT_RUN,    1'b0, 24'h0}, {PAT_RUN,    1'b0, 24'h0}, {PAT_RUN,    1'b0, 24'h0}
  };

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [2:0] key_sample, [7:3] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // segments, digit_select, relay_on, minutes_left,
                          // seconds_left, zero pad

  minute_countdown_timer_controller u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // Model state of the timer.
  logic [7:0] debounce_len;
  logic [6:0] sub_tick;
  logic [5:0] secs;
  logic [6:0] mins;
  logic [6:0] preset;
  logic       run_on;
  logic       blink_on;
  logic       show_tens;
  logic       ones_flash;
  logic       tens_flash;
  logic       key_armed;
  key_code_t  held_key;
  logic [7:0] held_count;

  tick_word_t  tick_words_due [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          words_out = 0;
  int          idle_cycles = 0;
  logic        hold_done = 1'b0;
  logic        steady_send = 1'b0;
  logic        row_typed = 1'b0;
  logic [23:0] row_word = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] glyph(input logic [6:0] digit);
    return (digit < 7'd10) ? DIGIT_GLYPHS[digit[3:0]] : SEG_BLANK;
  endfunction

  function automatic void enter_stopped();
    run_on     = 1'b0;
    blink_on   = 1'b0;
    show_tens  = 1'b0;
    ones_flash = 1'b0;
    tens_flash = 1'b1;
    key_armed  = 1'b0;
  endfunction

  // One 8 ms tick: sub-second counter, display scan, debounce, key action,
  // then the expiry check.
  function automatic tick_word_t advance_tick(input logic [2:0] keys);
    tick_word_t r;
    key_code_t  code;
    r = '0;

    sub_tick = sub_tick + 7'd1;
    if (sub_tick == BLINK_OFF_TICK) begin
      blink_on = 1'b0;
    end else if (sub_tick == BLINK_ON_TICK) begin
      blink_on = 1'b1;
    end else if (sub_tick == TICKS_PER_SECOND) begin
      sub_tick = '0;
      if (run_on) begin
        if (secs == 6'd0) begin
          secs = SECONDS_MAX;
          if (mins != 7'd0) mins = mins - 7'd1;
        end else begin
          secs = secs - 6'd1;
        end
      end
    end

    if (show_tens) begin
      show_tens = 1'b0;
      r.digit_sel = 1'b1;
      r.segments = glyph(mins / 7'd10);
      if (tens_flash && blink_on) r.segments = SEG_BLANK;
    end else begin
      show_tens = 1'b1;
      r.digit_sel = 1'b0;
      r.segments = glyph(mins % 7'd10);
      if (ones_flash && blink_on) r.segments = SEG_BLANK;
      if (run_on && blink_on) r.segments[7] = 1'b0;
    end

    case (keys)
      PAT_SELECT: code = KEY_SELECT;
      PAT_SET:    code = KEY_SET;
      PAT_RUN:    code = KEY_RUN;
      default:    code = KEY_NONE;
    endcase
    if (!key_armed) begin
      if (code != KEY_NONE) begin
        if (code == held_key) begin
          held_count = held_count + 8'd1;
          if (held_count >= debounce_len) begin
            key_armed = 1'b1;
            held_count = '0;
          end
        end else begin
          held_key = code;
          held_count = '0;
        end
      end else begin
        held_count = '0;
        held_key = KEY_NONE;
      end
    end

    if (key_armed) begin
      if (run_on) begin
        case (held_key)
          KEY_SELECT: if (mins < MINUTES_MAX) mins = mins + 7'd1;
          KEY_SET: begin
            if (mins >= 7'd1) mins = mins - 7'd1;
            else secs = '0;
          end
          KEY_RUN: enter_stopped();
          default: ;
        endcase
      end else begin
        case (held_key)
          KEY_SELECT: begin
            if (ones_flash) begin
              tens_flash = 1'b1;
              ones_flash = 1'b0;
            end else begin
              ones_flash = 1'b1;
              tens_flash = 1'b0;
            end
          end
          KEY_SET: begin
            // The flashing digit steps up and wraps from nine to zero.
            if (tens_flash) begin
              if (mins / 7'd10 == 7'd9) mins = mins - 7'd90;
              else mins = mins + 7'd10;
            end else begin
              if (mins % 7'd10 == 7'd9) mins = mins - 7'd9;
              else mins = mins + 7'd1;
            end
          end
          KEY_RUN: begin
            if (mins != 7'd0) begin
              run_on = 1'b1;
              tens_flash = 1'b0;
              ones_flash = 1'b0;
              sub_tick = '0;
              preset = mins;
            end
          end
          default: ;
        endcase
      end
      key_armed = 1'b0;
      held_key = KEY_NONE;
    end

    if (mins == 7'd0 && secs == 6'd0) begin
      enter_stopped();
      sub_tick = '0;
      mins = preset;
      secs = '0;
    end

    r.relay_on = run_on;
    r.minutes = mins;
    r.seconds = secs;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
  endtask

  task automatic compare_word(input tick_word_t want, input tick_word_t got);
    if (got.segments !== want.segments)   report_field("segments", want.segments, got.segments);
    if (got.digit_sel !== want.digit_sel) report_field("digit_select", want.digit_sel,
                                                       got.digit_sel);
    if (got.relay_on !== want.relay_on)   report_field("relay_on", want.relay_on, got.relay_on);
    if (got.minutes !== want.minutes)     report_field("minutes_left", want.minutes,
                                                       got.minutes);
    if (got.seconds !== want.seconds)     report_field("seconds_left", want.seconds,
                                                       got.seconds);
    if (got.pad !== want.pad)             report_field("pad", want.pad, got.pad);
  endtask

  // Presents one key sample and returns at the falling edge after it was taken.
  task automatic send_sample(input logic [2:0] keys, input logic typed,
                             input logic [23:0] word);
    int gap;
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, keys};
    row_typed = typed;
    row_word = word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Holds a pattern for a number of words, stopping early at the phase goal.
  task automatic hold_keys(input logic [2:0] keys, input int count, input int goal);
    for (int i = 0; i < count && items_sent < goal; i++) begin
      send_sample(keys, 1'b0, '0);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (tick_words_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Mostly clean presses, some bounced presses, noise and long idle stretches.
  task automatic drive_random(input int goal);
    int kind;
    int len;
    int dbl;
    int pick;
    logic [2:0] pat;
    while (items_sent < goal) begin
      dbl = int'(debounce_len);
      pick = $urandom_range(99);
      // While running, favor the set key so that the countdown reaches zero.
      if (run_on) pat = (pick < 15) ? PAT_SELECT : (pick < 85) ? PAT_SET : PAT_RUN;
      else        pat = (pick < 35) ? PAT_SELECT : (pick < 75) ? PAT_SET : PAT_RUN;
      kind = $urandom_range(99);
      if (kind < 60) begin
        len = dbl + 1 + $urandom_range(2);
        if ($urandom_range(7) == 0) len = len + dbl + 1;
        hold_keys(pat, len, goal);
        hold_keys(PAT_NONE, $urandom_range(1, 6), goal);
      end else if (kind < 72) begin
        hold_keys(pat, (dbl == 0) ? 1 : $urandom_range(1, dbl), goal);
        hold_keys(3'($urandom_range(7)), 1, goal);
      end else if (kind < 87) begin
        repeat ($urandom_range(1, 8)) hold_keys(3'($urandom_range(7)), 1, goal);
      end else begin
        hold_keys(PAT_NONE, $urandom_range(40, 200), goal);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    tick_word_t want;
    tick_word_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = advance_tick(s_tdata[2:0]);
        if (row_typed) want = row_word;
        tick_words_due.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        words_out++;
        if (tick_words_due.size() == 0) begin
          mismatches++;
          $display("%0t: word with nothing expected, got %h", $time, got);
        end else begin
          want = tick_words_due.pop_front();
          compare_word(want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver: random ready stretches, plus one long hold-off so the block fills up.
  initial begin : sink
    int run_len;
    int gap;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (!hold_done && words_out >= HOLD_AFTER) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (SINK_HOLD) @(negedge clk);
      end
      run_len = ($urandom_range(3) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      m_tready <= 1'b1;
      repeat (run_len) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int goal;
    logic [7:0] cfg_value;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;

    debounce_len = DEBOUNCE_RESET;
    sub_tick = '0;
    secs = '0;
    mins = PRESET_RESET;
    preset = PRESET_RESET;
    run_on = 1'b0;
    blink_on = 1'b0;
    show_tens = 1'b0;
    ones_flash = 1'b0;
    tens_flash = 1'b1;
    key_armed = 1'b0;
    held_key = KEY_NONE;
    held_count = '0;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_sample(directed_rows[i].keys, directed_rows[i].typed, directed_rows[i].word);
    end
    row_typed = 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (PHASE_DEBOUNCE[p] == RANDOM_DEBOUNCE) cfg_value = 8'($urandom_range(1, 254));
      else cfg_value = 8'(PHASE_DEBOUNCE[p]);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= cfg_value;
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      debounce_len = cfg_value;
      steady_send = (p == 1 || p == 4);
      goal = items_sent + PHASE_ITEMS[p];
      drive_random(goal);
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && tick_words_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
